@@ src/utf8_string_validator_unit_defines.svh @@
// Assertion macros shared by the UTF-8 string validator checker.
`ifndef UTF8_STRING_VALIDATOR_UNIT_DEFINES_SVH
`define UTF8_STRING_VALIDATOR_UNIT_DEFINES_SVH

// Check on every edge, reset included.
`define U8SV_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

// Same-cycle implication, off while reset is asserted.
`define U8SV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define U8SV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/utf8sv_pkg.sv @@
// Types, constants and register indexes for the UTF-8 string validator.
package utf8sv_pkg;

	localparam int MAX_LEN_DEF = 4096;
	localparam int MAX_LENGTH_RST = 4096;
	localparam logic REQUIRE_NONEMPTY_RST = 1'b1;

	localparam int CFG_DATA_W = 13;
	localparam int CFG_INDEX_W = 1;
	localparam int COUNT_W = 13;
	localparam int CP_W = 21;

	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_REQUIRE_NONEMPTY = 1'b1;

	localparam logic [7:0] LEAD2_MASK = 8'he0;
	localparam logic [7:0] LEAD2_CODE = 8'hc0;
	localparam logic [7:0] LEAD3_MASK = 8'hf0;
	localparam logic [7:0] LEAD3_CODE = 8'he0;
	localparam logic [7:0] LEAD4_MASK = 8'hf8;
	localparam logic [7:0] LEAD4_CODE = 8'hf0;
	localparam logic [7:0] CONT_MASK = 8'hc0;
	localparam logic [7:0] CONT_CODE = 8'h80;
	localparam logic [7:0] LEAD2_PAYLOAD = 8'h1f;
	localparam logic [7:0] LEAD3_PAYLOAD = 8'h0f;
	localparam logic [7:0] LEAD4_PAYLOAD = 8'h07;

	localparam logic [CP_W-1:0] MIN_CP2 = 21'h80;
	localparam logic [CP_W-1:0] MIN_CP3 = 21'h800;
	localparam logic [CP_W-1:0] MIN_CP4 = 21'h10000;
	localparam logic [CP_W-1:0] MAX_CP = 21'h10ffff;
	localparam logic [CP_W-1:0] SURR_LO = 21'hd800;
	localparam logic [CP_W-1:0] SURR_HI = 21'hdfff;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
		logic       empty_marker;
	} in_item_t;

	typedef struct packed {
		logic               is_valid;
		logic [COUNT_W-1:0] byte_count;
	} out_item_t;

	typedef struct packed {
		logic [1:0]      pend;
		logic [1:0]      seq_len;
		logic [CP_W-1:0] cp;
		logic            err;
	} dec_state_t;

endpackage

@@ src/utf8_string_validator_unit.sv @@
// Top level of the UTF-8 string validator: input register, decode, verdict register.
//
// Usage:
//   A string arrives as beats on the byte channel (byte_valid/byte_ready,
//   payload byte_item), one byte a beat, end_of_string set on the last one.
//   An empty string is a single beat with empty_marker and end_of_string set;
//   an empty_marker beat without end_of_string is dropped.
//   Each string yields one beat on the verdict channel (verdict_valid/
//   verdict_ready, payload verdict_item): is_valid and the byte count, which
//   saturates at the limit plus one.
//   The last byte goes from the input register via decode into the verdict register.
//   Throughput: one byte per cycle unless an end-of-string beat waits on a stalled
//   verdict, set by the single decode step between input and string state registers.
//   A stalled verdict holds; the input register then keeps taking beats up to
//   the next end-of-string beat, which waits there until the verdict drains.
//   Reset clears the string state and both valids and loads the limit with
//   min(4096, MAX_LEN) and require_nonempty with 1. Write the configuration
//   port (cfg_we, cfg_index, cfg_data) only while no string is in progress.
module utf8_string_validator_unit #(
	parameter int MAX_LEN = utf8sv_pkg::MAX_LEN_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               byte_valid,
	output logic                               byte_ready,
	input  utf8sv_pkg::in_item_t               byte_item,
	output logic                               verdict_valid,
	input  logic                               verdict_ready,
	output utf8sv_pkg::out_item_t              verdict_item,
	input  logic                               cfg_we,
	input  logic [utf8sv_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [utf8sv_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CNT_W = $clog2(MAX_LEN + 2);

	logic                   valid_s1;
	utf8sv_pkg::in_item_t   item_s1;
	utf8sv_pkg::dec_state_t st_q;
	utf8sv_pkg::dec_state_t st_nxt;
	logic [CNT_W-1:0]       len_q;
	logic [CNT_W-1:0]       len_nxt;
	logic                   out_valid_q;
	utf8sv_pkg::out_item_t  out_item_q;
	utf8sv_pkg::out_item_t  result;
	logic [CNT_W-1:0]       limit;
	logic                   require_nonempty;
	logic                   advance;

	utf8sv_cfg #(
		.MAX_LEN(MAX_LEN),
		.CNT_W(CNT_W)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.limit(limit),
		.require_nonempty(require_nonempty)
	);

	utf8sv_decode #(
		.CNT_W(CNT_W)
	) u_decode (
		.item(item_s1),
		.st(st_q),
		.len(len_q),
		.limit(limit),
		.require_nonempty(require_nonempty),
		.st_nxt(st_nxt),
		.len_nxt(len_nxt),
		.result(result)
	);

	assign advance = valid_s1 && (!item_s1.end_of_string || !out_valid_q || verdict_ready);
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			item_s1 <= byte_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			len_q <= '0;
		end else if (advance) begin
			if (item_s1.end_of_string) begin
				st_q <= '0;
				len_q <= '0;
			end else begin
				st_q <= st_nxt;
				len_q <= len_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && item_s1.end_of_string) begin
			out_valid_q <= 1'b1;
		end else if (verdict_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.end_of_string) begin
			out_item_q <= result;
		end
	end

	assign verdict_valid = out_valid_q;
	assign verdict_item = out_item_q;

endmodule

@@ src/utf8sv_cfg.sv @@
// Configuration registers: clamped length limit and non-empty requirement.
module utf8sv_cfg #(
	parameter int MAX_LEN = utf8sv_pkg::MAX_LEN_DEF,
	parameter int CNT_W = $clog2(MAX_LEN + 2)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [utf8sv_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [utf8sv_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic [CNT_W-1:0]                     limit,
	output logic                                 require_nonempty
);

	localparam int LIMIT_RST = (utf8sv_pkg::MAX_LENGTH_RST > MAX_LEN) ?
		MAX_LEN : utf8sv_pkg::MAX_LENGTH_RST;

	logic [CNT_W-1:0] limit_q;
	logic             req_q;
	logic [31:0]      wr_ext;
	logic [31:0]      wr_lim;

	always_comb begin
		wr_ext = 32'(cfg_data);
		wr_lim = (wr_ext > 32'(MAX_LEN)) ? 32'(MAX_LEN) : wr_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= CNT_W'(LIMIT_RST);
			req_q   <= utf8sv_pkg::REQUIRE_NONEMPTY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				utf8sv_pkg::CFG_MAX_LENGTH: begin
					limit_q <= wr_lim[CNT_W-1:0];
				end
				utf8sv_pkg::CFG_REQUIRE_NONEMPTY: begin
					req_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign limit = limit_q;
	assign require_nonempty = req_q;

endmodule

@@ src/utf8sv_decode.sv @@
// One-byte UTF-8 decode step: next string state, length and verdict.
module utf8sv_decode #(
	parameter int CNT_W = $clog2(utf8sv_pkg::MAX_LEN_DEF + 2)
) (
	input  utf8sv_pkg::in_item_t   item,
	input  utf8sv_pkg::dec_state_t st,
	input  logic [CNT_W-1:0]       len,
	input  logic [CNT_W-1:0]       limit,
	input  logic                   require_nonempty,
	output utf8sv_pkg::dec_state_t st_nxt,
	output logic [CNT_W-1:0]       len_nxt,
	output utf8sv_pkg::out_item_t  result
);

	logic [7:0]                  b;
	logic [utf8sv_pkg::CP_W-1:0] cp_sh;
	logic                        bad_cp;
	logic                        fail;
	logic [31:0]                 len_ext;

	always_comb begin
		b = item.data_byte;
		cp_sh = {st.cp[utf8sv_pkg::CP_W-7:0], b[5:0]};
		bad_cp = ((st.seq_len == 2'd1) && (cp_sh < utf8sv_pkg::MIN_CP2)) ||
			((st.seq_len == 2'd2) && (cp_sh < utf8sv_pkg::MIN_CP3)) ||
			((st.seq_len == 2'd3) && (cp_sh < utf8sv_pkg::MIN_CP4)) ||
			(cp_sh > utf8sv_pkg::MAX_CP) ||
			((cp_sh >= utf8sv_pkg::SURR_LO) && (cp_sh <= utf8sv_pkg::SURR_HI));
		st_nxt = st;
		len_nxt = len;
		fail = 1'b0;
		if (!item.empty_marker) begin
			if (len <= limit) begin
				len_nxt = len + CNT_W'(1);
			end
			priority if (b == 8'h00) begin
				fail = 1'b1;
			end else if (st.pend == 2'd0) begin
				priority if (!b[7]) begin
				end else if ((b & utf8sv_pkg::LEAD2_MASK) == utf8sv_pkg::LEAD2_CODE) begin
					st_nxt.pend = 2'd1;
					st_nxt.seq_len = 2'd1;
					st_nxt.cp = utf8sv_pkg::CP_W'(b & utf8sv_pkg::LEAD2_PAYLOAD);
				end else if ((b & utf8sv_pkg::LEAD3_MASK) == utf8sv_pkg::LEAD3_CODE) begin
					st_nxt.pend = 2'd2;
					st_nxt.seq_len = 2'd2;
					st_nxt.cp = utf8sv_pkg::CP_W'(b & utf8sv_pkg::LEAD3_PAYLOAD);
				end else if ((b & utf8sv_pkg::LEAD4_MASK) == utf8sv_pkg::LEAD4_CODE) begin
					st_nxt.pend = 2'd3;
					st_nxt.seq_len = 2'd3;
					st_nxt.cp = utf8sv_pkg::CP_W'(b & utf8sv_pkg::LEAD4_PAYLOAD);
				end else begin
					fail = 1'b1;
				end
			end else if ((b & utf8sv_pkg::CONT_MASK) != utf8sv_pkg::CONT_CODE) begin
				fail = 1'b1;
			end else begin
				st_nxt.pend = st.pend - 2'd1;
				if (st.pend == 2'd1) begin
					fail = bad_cp;
					st_nxt.seq_len = 2'd0;
					st_nxt.cp = '0;
				end else begin
					st_nxt.cp = cp_sh;
				end
			end
			if (fail) begin
				st_nxt.err = 1'b1;
				st_nxt.pend = 2'd0;
				st_nxt.seq_len = 2'd0;
				st_nxt.cp = '0;
			end
		end
		len_ext = 32'(len_nxt);
		result.is_valid = !st_nxt.err && (st_nxt.pend == 2'd0) &&
			!(require_nonempty && (len_nxt == '0)) && (len_nxt <= limit);
		result.byte_count = len_ext[utf8sv_pkg::COUNT_W-1:0];
	end

endmodule

@@ src/utf8sv_checker.sv @@
// Port-level checker for the UTF-8 string validator, bound to the top level.
`include "utf8_string_validator_unit_defines.svh"

module utf8sv_checker #(
	parameter int MAX_LEN = utf8sv_pkg::MAX_LEN_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  byte_valid,
	input logic                  byte_ready,
	input utf8sv_pkg::in_item_t  byte_item,
	input logic                  verdict_valid,
	input logic                  verdict_ready,
	input utf8sv_pkg::out_item_t verdict_item
);

	`U8SV_ASSERT_ALWAYS(a_no_verdict_in_reset, clk, !arst_n |-> !verdict_valid, "verdict during reset")
	`U8SV_ASSERT_NEXT(a_verdict_holds, clk, arst_n, verdict_valid && !verdict_ready, verdict_valid && $stable(verdict_item), "stalled verdict changed")
	`U8SV_ASSERT_IMPL(a_ready_when_drained, clk, arst_n, !verdict_valid, byte_ready, "byte channel stalled with empty verdict register")
	`U8SV_ASSERT_IMPL(a_verdict_follows_end, clk, arst_n, $rose(verdict_valid), $past(byte_valid && byte_ready && byte_item.end_of_string, 2), "verdict without end-of-string beat")
	`U8SV_ASSERT_IMPL(a_valid_within_limit, clk, arst_n, verdict_valid && verdict_item.is_valid, 32'(verdict_item.byte_count) <= 32'(MAX_LEN), "accepted string longer than limit")

endmodule

bind utf8_string_validator_unit utf8sv_checker #(
	.MAX_LEN(MAX_LEN)
) u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.byte_valid(byte_valid),
	.byte_ready(byte_ready),
	.byte_item(byte_item),
	.verdict_valid(verdict_valid),
	.verdict_ready(verdict_ready),
	.verdict_item(verdict_item)
);
